[design/isi_pkg.sv]
`default_nettype none
package isi_pkg;

  localparam int DEFAULT_MAX_RANGES = 64;
  localparam int ADDR_W  = 32;
  localparam int TOTAL_W = 7;

  localparam logic [31:0] WINDOW_BASE_RESET = 32'h8000_0000;
  localparam logic [31:0] WINDOW_SIZE_RESET = 32'h0180_0000;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic CFG_WINDOW_BASE = 1'b0;
  localparam logic CFG_WINDOW_SIZE = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_EVAL,
    CELL_SHIFT,
    CELL_ABSORB
  } cell_op_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_t          op;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W:0]   last;   // addr + size, no wrap
  } cell_ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
    logic              below;  // ends before the request starts
    logic              merge;  // overlaps or touches the request
  } cell_st_t;

endpackage
`default_nettype wire

[design/isi_cell.sv]
`default_nettype none
module isi_cell #(
  parameter bit FIRST = 1'b0
) (
  input  wire                 clk,
  input  wire                 rst,
  input  isi_pkg::cell_ctl_t  ctl,
  input  wire                 valid,
  input  isi_pkg::cell_st_t   lft,
  input  isi_pkg::cell_st_t   rgt,
  output isi_pkg::cell_st_t   st,
  output logic                hit
);
  import isi_pkg::*;

  logic [ADDR_W-1:0] start, start_next;
  logic [ADDR_W-1:0] len, len_next;
  logic              below, below_next;
  logic              merge, merge_next;
  logic              head, head_next;
  logic              tail, tail_next;
  logic              hit_next;

  logic [ADDR_W:0]   end_own, end_rgt, first_m, last_m, span;
  logic              ends_before;

  always_comb begin
    end_own     = {1'b0, start} + {1'b0, len};
    end_rgt     = {1'b0, rgt.start} + {1'b0, rgt.len};
    ends_before = end_own < {1'b0, ctl.addr};
    first_m     = ({1'b0, rgt.start} < {1'b0, start}) ? {1'b0, rgt.start} : {1'b0, start};
    last_m      = (end_rgt > end_own) ? end_rgt : end_own;
    span        = last_m - first_m;

    start_next = start;
    len_next   = len;
    below_next = below;
    merge_next = merge;
    head_next  = head;
    tail_next  = tail;
    hit_next   = hit;

    unique case (ctl.op)
      CELL_EVAL: begin
        below_next = valid && ends_before;
        merge_next = valid && !ends_before && ({1'b0, start} <= ctl.last);
        hit_next   = valid && (start <= ctl.addr) && ({1'b0, ctl.addr} < end_own);
        head_next  = 1'b0;
        tail_next  = 1'b0;
      end
      CELL_SHIFT: begin
        if (below) begin
          head_next = 1'b0;
          tail_next = 1'b0;
        end else if (FIRST || lft.below) begin
          start_next = ctl.addr;
          len_next   = ctl.size;
          merge_next = 1'b0;
          head_next  = 1'b1;
          tail_next  = 1'b0;
        end else begin
          start_next = lft.start;
          len_next   = lft.len;
          merge_next = lft.merge;
          head_next  = 1'b0;
          tail_next  = 1'b1;
        end
        below_next = 1'b0;
      end
      CELL_ABSORB: begin
        if (head && rgt.merge) begin
          start_next = first_m[ADDR_W-1:0];
          // length saturates once the span no longer fits
          len_next   = span[ADDR_W] ? {ADDR_W{1'b1}} : span[ADDR_W-1:0];
        end else if (tail) begin
          start_next = rgt.start;
          len_next   = rgt.len;
          merge_next = rgt.merge;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    start <= start_next;
    len   <= len_next;
    if (rst) begin
      below <= 1'b0;
      merge <= 1'b0;
      head  <= 1'b0;
      tail  <= 1'b0;
      hit   <= 1'b0;
    end else begin
      below <= below_next;
      merge <= merge_next;
      head  <= head_next;
      tail  <= tail_next;
      hit   <= hit_next;
    end
  end

  assign st.start = start;
  assign st.len   = len;
  assign st.below = below;
  assign st.merge = merge;

endmodule
`default_nettype wire

[design/interval_set_merge_insert.sv]
// Flow: query, clear and rejected insert go from S_EVAL to S_DECIDE, which registers the result beat;
//   an accepted insert goes on to S_ABSORB, absorbing the stored ranges it merges, then registers its result beat.
// Throughput: one request at a time; the next input beat is taken once the result is out
//   or being taken; an insert absorbs one merge per cycle.
// Reset: range count cleared, window registers back to their reset values, no beat pending.
`default_nettype none
module interval_set_merge_insert #(
  parameter int MAX_RANGES = isi_pkg::DEFAULT_MAX_RANGES
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,   // address[31:0], size[63:32]
  input  wire  [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // accepted[0], covered[1], range_total[8:2], zero fill
  input  wire         cfg_write,
  input  wire         cfg_index,
  input  wire  [31:0] cfg_data
);
  import isi_pkg::*;

  localparam int NCELL = MAX_RANGES + 1;   // one spare cell for the insert shift
  localparam int CW    = $clog2(MAX_RANGES + 2);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DECIDE, S_ABSORB} state_t;

  state_t            state;
  logic [31:0]       window_base, window_size;
  logic [CW-1:0]     count;
  logic [1:0]        req_type;
  logic [31:0]       req_addr, req_size;
  logic              win_ok;
  logic              res_acc, res_cov;
  logic [TOTAL_W-1:0] res_total;

  cell_ctl_t         ctl;
  cell_st_t          cst [NCELL];
  logic [NCELL-1:0]  cov_bits, merge_bits;
  logic              any_merge, any_cover, full, insert_go;
  logic              in_fire;
  logic [32:0]       req_last, in_last, win_lim;

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign in_fire  = s_tvalid && s_tready;
  assign in_last  = {1'b0, s_tdata[31:0]} + {1'b0, s_tdata[63:32]};
  assign win_lim  = {1'b0, window_base} + {1'b0, window_size};
  assign req_last = {1'b0, req_addr} + {1'b0, req_size};

  assign any_merge = |merge_bits;
  assign any_cover = |cov_bits;
  assign full      = (count == CW'(MAX_RANGES));
  assign insert_go = win_ok && !(full && !any_merge);

  always_comb begin
    ctl.addr = req_addr;
    ctl.size = req_size;
    ctl.last = req_last;
    ctl.op   = CELL_HOLD;
    if (state == S_EVAL) begin
      ctl.op = CELL_EVAL;
    end else if (state == S_DECIDE && req_type == REQ_INSERT && insert_go) begin
      ctl.op = CELL_SHIFT;
    end else if (state == S_ABSORB && any_merge) begin
      ctl.op = CELL_ABSORB;
    end
  end

  localparam cell_st_t EDGE_ST = '0;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    isi_cell #(
      .FIRST (j == 0)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .valid (count > CW'(j)),
      .lft   ((j == 0) ? EDGE_ST : cst[(j == 0) ? 0 : j - 1]),
      .rgt   ((j == NCELL - 1) ? EDGE_ST : cst[(j == NCELL - 1) ? j : j + 1]),
      .st    (cst[j]),
      .hit   (cov_bits[j])
    );
    assign merge_bits[j] = cst[j].merge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window_base <= WINDOW_BASE_RESET;
      window_size <= WINDOW_SIZE_RESET;
      count       <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_WINDOW_BASE: window_base <= cfg_data;
          CFG_WINDOW_SIZE: window_size <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: state <= S_DECIDE;
        S_DECIDE: begin
          state <= S_IDLE;
          unique case (req_type)
            REQ_QUERY: begin
              res_acc   <= 1'b0;
              res_cov   <= any_cover;
              res_total <= TOTAL_W'(count);
              m_tvalid  <= 1'b1;
            end
            REQ_CLEAR: begin
              count     <= '0;
              res_acc   <= 1'b1;
              res_cov   <= 1'b0;
              res_total <= '0;
              m_tvalid  <= 1'b1;
            end
            REQ_INSERT: begin
              if (insert_go) begin
                count <= count + CW'(1);
                state <= S_ABSORB;
              end else begin
                res_acc   <= 1'b0;
                res_cov   <= 1'b0;
                res_total <= TOTAL_W'(count);
                m_tvalid  <= 1'b1;
              end
            end
            default: begin
              res_acc   <= 1'b0;
              res_cov   <= 1'b0;
              res_total <= TOTAL_W'(count);
              m_tvalid  <= 1'b1;
            end
          endcase
        end
        S_ABSORB: begin
          if (any_merge) begin
            count <= count - CW'(1);
          end else begin
            res_acc   <= 1'b1;
            res_cov   <= 1'b0;
            res_total <= TOTAL_W'(count);
            m_tvalid  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request capture; window test done on the input beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type <= s_tuser;
      req_addr <= s_tdata[31:0];
      req_size <= s_tdata[63:32];
      win_ok   <= (s_tdata[63:32] != 32'd0) && (s_tdata[31:0] >= window_base) &&
                  (s_tdata[63:32] <= window_size) && (in_last <= win_lim);
    end
  end

  assign m_tdata = {7'd0, res_total, res_cov, res_acc};

endmodule
`default_nettype wire
